@@ hdl/cle_pkg.sv @@
// Shared types and constants for the cursor line editor.
package cle_pkg;

    localparam int KeyW    = 8;
    localparam int LenW    = 6;
    localparam int LimW    = LenW + 1;
    localparam int CfgIdxW = 3;
    localparam int DataW   = 16;
    localparam int PadW    = DataW - KeyW - LenW;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BACKSPACE = 3'd0,
        CFG_LEFT      = 3'd1,
        CFG_RIGHT     = 3'd2,
        CFG_ENDLINE   = 3'd3,
        CFG_LIMIT     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_BACKSPACE,
        OP_LEFT,
        OP_RIGHT,
        OP_ENDLINE,
        OP_CHAR
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_LINE   = 2'd3
    } kind_t;

    typedef struct packed {
        op_t             op;
        logic [KeyW-1:0] key;
    } cmd_t;

    localparam logic [KeyW-1:0] RstBackspace = 8'd8;
    localparam logic [KeyW-1:0] RstLeft      = 8'd17;
    localparam logic [KeyW-1:0] RstRight     = 8'd18;
    localparam logic [KeyW-1:0] RstEndline   = 8'd10;
    localparam logic [LenW-1:0] RstLimit     = 6'd32;

endpackage

@@ hdl/cle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cle_front.sv @@
// Front end: configuration registers and key classification.
module cle_front #(
    parameter int LINE_MAX = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cle_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [cle_pkg::KeyW-1:0]          cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cle_pkg::KeyW-1:0]          s_tdata,
    output logic                              push_valid,
    input  logic                              push_ready,
    output cle_pkg::cmd_t                     push_cmd,
    output logic [$clog2(LINE_MAX+1)-1:0]     eff_limit
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_MAX + 1);

    logic [KeyW-1:0] bs_code_reg;
    logic [KeyW-1:0] left_code_reg;
    logic [KeyW-1:0] right_code_reg;
    logic [KeyW-1:0] end_code_reg;
    logic [LenW-1:0] limit_reg;
    logic [LenW-1:0] lim_clamped;
    op_t             op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_code_reg    <= RstBackspace;
            left_code_reg  <= RstLeft;
            right_code_reg <= RstRight;
            end_code_reg   <= RstEndline;
            limit_reg      <= RstLimit;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BACKSPACE: bs_code_reg    <= cfg_data;
                CFG_LEFT:      left_code_reg  <= cfg_data;
                CFG_RIGHT:     right_code_reg <= cfg_data;
                CFG_ENDLINE:   end_code_reg   <= cfg_data;
                CFG_LIMIT:     limit_reg      <= cfg_data[LenW-1:0];
                default:       ;
            endcase
        end
    end

    // zero acts as one, anything beyond the store depth is clamped
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim_clamped = LenW'(1);
        end
        else if ({1'b0, limit_reg} > LimW'(LINE_MAX))
        begin
            lim_clamped = LenW'(LINE_MAX);
        end
        else
        begin
            lim_clamped = limit_reg;
        end
    end

    assign eff_limit = CW'(lim_clamped);

    // first match wins: backspace, left, right, end of line
    always_comb
    begin
        if (s_tdata == bs_code_reg)
        begin
            op = OP_BACKSPACE;
        end
        else if (s_tdata == left_code_reg)
        begin
            op = OP_LEFT;
        end
        else if (s_tdata == right_code_reg)
        begin
            op = OP_RIGHT;
        end
        else if (s_tdata == end_code_reg)
        begin
            op = OP_ENDLINE;
        end
        else
        begin
            op = OP_CHAR;
        end
    end

    assign s_tready     = push_ready;
    assign push_valid   = s_tvalid;
    assign push_cmd.op  = op;
    assign push_cmd.key = s_tdata;

endmodule

@@ hdl/cle_queue.sv @@
// Two-entry command queue between front and back end.
module cle_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cle_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output cle_pkg::cmd_t out_cmd
);
    import cle_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ hdl/cle_back.sv @@
// Back end: line store, cursor bookkeeping, tail shifting and line output.
module cle_back #(
    parameter int LINE_MAX = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  cle_pkg::cmd_t                 cmd,
    input  logic [$clog2(LINE_MAX+1)-1:0] eff_limit,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cle_pkg::DataW-1:0]     m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int AW = $clog2(LINE_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_ECHO,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   cursor_reg;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   stop_reg;
    logic [CW-1:0]   len_reg;
    logic            up_reg;
    logic            end_reg;
    logic [KeyW-1:0] key_reg;
    kind_t           kind_reg;

    logic            out_valid_reg;
    kind_t           out_kind_reg;
    logic [KeyW-1:0] out_char_reg;
    logic [LenW-1:0] out_len_reg;
    logic            out_last_reg;

    logic            slot_free;
    logic            out_load;
    logic            closing;
    logic [CW-1:0]   src_idx;
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [KeyW-1:0] ram_wdata;
    logic [KeyW-1:0] ram_rdata;

    cle_ram #(
        .WIDTH(KeyW),
        .DEPTH(LINE_MAX)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign out_load  = slot_free && ((state_reg == S_ECHO) || (state_reg == S_DUMP_OUT));
    assign cmd_ready = (state_reg == S_IDLE);
    assign closing   = end_reg || (count_reg >= eff_limit);
    assign src_idx   = up_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;

    // one element moves per read/write pair on the single read port
    always_comb
    begin
        ram_re    = (state_reg == S_SHIFT_RD) || (state_reg == S_DUMP_RD);
        ram_raddr = (state_reg == S_SHIFT_RD) ? src_idx[AW-1:0] : idx_reg[AW-1:0];
        ram_we    = (state_reg == S_SHIFT_WR) || (state_reg == S_PUT);
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = (state_reg == S_PUT) ? key_reg : ram_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            idx_reg       <= '0;
            stop_reg      <= '0;
            len_reg       <= '0;
            up_reg        <= 1'b0;
            end_reg       <= 1'b0;
            key_reg       <= '0;
            kind_reg      <= KIND_NONE;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_NONE;
            out_char_reg  <= '0;
            out_len_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        key_reg <= cmd.key;
                        end_reg <= (cmd.op == OP_ENDLINE);
                        case (cmd.op)
                            OP_BACKSPACE:
                            begin
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - 1'b1;
                                    count_reg  <= count_reg - 1'b1;
                                    kind_reg   <= KIND_WRITE;
                                    // close the gap from the new cursor upward
                                    if (cursor_reg != count_reg)
                                    begin
                                        idx_reg   <= cursor_reg - 1'b1;
                                        stop_reg  <= count_reg - CW'(2);
                                        up_reg    <= 1'b1;
                                        state_reg <= S_SHIFT_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_ECHO;
                                    end
                                end
                                else
                                begin
                                    kind_reg  <= KIND_NONE;
                                    state_reg <= S_ECHO;
                                end
                            end
                            OP_LEFT:
                            begin
                                state_reg <= S_ECHO;
                                if (cursor_reg != '0)
                                begin
                                    cursor_reg <= cursor_reg - 1'b1;
                                    kind_reg   <= KIND_WRITE;
                                end
                                else
                                begin
                                    kind_reg <= KIND_NONE;
                                end
                            end
                            OP_RIGHT:
                            begin
                                state_reg <= S_ECHO;
                                if (cursor_reg < count_reg)
                                begin
                                    cursor_reg <= cursor_reg + 1'b1;
                                    kind_reg   <= KIND_WRITE;
                                end
                                else
                                begin
                                    kind_reg <= KIND_NONE;
                                end
                            end
                            OP_ENDLINE:
                            begin
                                idx_reg    <= count_reg;
                                count_reg  <= count_reg + 1'b1;
                                cursor_reg <= cursor_reg + 1'b1;
                                kind_reg   <= KIND_NONE;
                                state_reg  <= S_PUT;
                            end
                            OP_CHAR:
                            begin
                                count_reg  <= count_reg + 1'b1;
                                cursor_reg <= cursor_reg + 1'b1;
                                if (cursor_reg < count_reg)
                                begin
                                    // open a gap at the cursor, top element first
                                    kind_reg  <= KIND_INSERT;
                                    idx_reg   <= count_reg;
                                    stop_reg  <= cursor_reg + 1'b1;
                                    up_reg    <= 1'b0;
                                    state_reg <= S_SHIFT_RD;
                                end
                                else
                                begin
                                    kind_reg  <= KIND_WRITE;
                                    idx_reg   <= cursor_reg;
                                    state_reg <= S_PUT;
                                end
                            end
                            default:
                            begin
                                kind_reg  <= KIND_NONE;
                                state_reg <= S_ECHO;
                            end
                        endcase
                    end
                end
                S_SHIFT_RD:
                begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR:
                begin
                    idx_reg <= src_idx;
                    if (idx_reg == stop_reg)
                    begin
                        // a downward shift ends with idx on the insert place
                        state_reg <= up_reg ? S_ECHO : S_PUT;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_RD;
                    end
                end
                S_PUT:
                begin
                    state_reg <= S_ECHO;
                end
                S_ECHO:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= kind_reg;
                        out_char_reg  <= (kind_reg == KIND_NONE) ? '0 : key_reg;
                        out_len_reg   <= '0;
                        out_last_reg  <= !(closing && count_reg != '0);
                        state_reg     <= (closing && count_reg != '0) ? S_DUMP_RD : S_IDLE;
                        if (closing)
                        begin
                            len_reg    <= count_reg;
                            count_reg  <= '0;
                            cursor_reg <= '0;
                            idx_reg    <= '0;
                        end
                    end
                end
                S_DUMP_RD:
                begin
                    state_reg <= S_DUMP_OUT;
                end
                S_DUMP_OUT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_LINE;
                        out_char_reg  <= ram_rdata;
                        out_len_reg   <= LenW'(len_reg);
                        out_last_reg  <= (idx_reg + 1'b1 == len_reg);
                        if (idx_reg + 1'b1 == len_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DUMP_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PadW'(0), out_len_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond end of line");

    a_open_line_fits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> count_reg < CW'(LINE_MAX))
        else $error("open line fills the store");

    a_line_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_LINE |-> out_len_reg != '0)
        else $error("line byte with zero length");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP_RD |-> count_reg == '0 && cursor_reg == '0)
        else $error("line state not cleared while emitting");

endmodule

@@ hdl/cursor_line_editor_unit.sv @@
// Top level of the cursor line editor.
// Each key request is classified against the four configured key codes and
// queued (two entries); the back end then edits a line store held in a
// single-port-read RAM. A move or ignored key goes from idle straight to its
// echo, an append first writes the store; an insert or backspace first shifts
// the characters behind the cursor one at a time, because each
// move is one read and one write through the RAM's registered read port.
// When a line closes (end-of-line key, or the count reaching line_limit)
// every stored character follows the echo, each one read from the store
// and then put on the output. A stalled output holds the back end;
// the front keeps taking keys until the queue is full. No clearing pass
// after reset. Configuration may be written only while the block is idle.
module cursor_line_editor_unit #(
    parameter int LINE_MAX = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cle_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [cle_pkg::KeyW-1:0]      cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cle_pkg::KeyW-1:0]      s_tdata,   // [7:0] key_code
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cle_pkg::DataW-1:0]     m_tdata,   // [7:0] char_value, [13:8] line_length
    output logic [1:0]                    m_tuser,   // [1:0] kind
    output logic                          m_tlast
);
    import cle_pkg::*;

    localparam int CW = $clog2(LINE_MAX + 1);

    cmd_t          push_cmd;
    cmd_t          pop_cmd;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop_ready;
    logic [CW-1:0] eff_limit;

    cle_front #(
        .LINE_MAX(LINE_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_cmd  (push_cmd),
        .eff_limit (eff_limit)
    );

    cle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_cmd   (push_cmd),
        .out_valid(pop_valid),
        .out_ready(pop_ready),
        .out_cmd  (pop_cmd)
    );

    cle_back #(
        .LINE_MAX(LINE_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(pop_valid),
        .cmd_ready(pop_ready),
        .cmd      (pop_cmd),
        .eff_limit(eff_limit),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
